[rtl/point_keyed_event_heap_unit_assert.svh]
// Assertion macros for the event heap
`ifndef POINT_KEYED_EVENT_HEAP_UNIT_ASSERT_SVH
`define POINT_KEYED_EVENT_HEAP_UNIT_ASSERT_SVH

// clocked check, off during reset
`define PKEH_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

[rtl/pkeh_pkg.sv]
package pkeh_pkg;

  localparam int unsigned MAX_EVENTS_DEF  = 256;
  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam logic [8:0]  CAPACITY_RST    = 9'd256;

  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_PEEK    = 2'd1;
  localparam logic [1:0] ACT_EXTRACT = 2'd2;
  localparam logic [1:0] ACT_REMOVE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TOP_WAIT,
    S_REP_RD,
    S_REP,
    S_MOVE_RD,
    S_MOVE_WR,
    S_ENT_RD,
    S_ENT_WAIT,
    S_ENT_KEY,
    S_UP_RD,
    S_UP_WAIT,
    S_UP_CMP,
    S_UP_WR2,
    S_DN_RD,
    S_DN_W1,
    S_DN_K1,
    S_DN_W2,
    S_DN_K2,
    S_DN_SW1,
    S_DN_SW2,
    S_DONE
  } state_t;

endpackage

[rtl/point_keyed_event_heap_unit.sv]
// Indexed binary min-heap of events keyed on (y, x), signed fixed point.
// Each word on the input side returns exactly one result word, and the next
// input word is taken once that result has been loaded into the output
// register. Insert climbs level by level; extract and remove fetch and
// relocate entries, then sink the entry that fills the hole, or climb it
// on a remove, and any operation may wait on m_tready.
// Every sift step reads the position map, then the key memory, and writes
// two entries in each map, all through memories with registered reads.
// No clearing pass after reset; the user must set capacity on the cfg channel
// only while idle, and the block itself does not enforce it.
module point_keyed_event_heap_unit
  #(parameter int unsigned MAX_EVENTS  = pkeh_pkg::MAX_EVENTS_DEF,
    parameter int unsigned COORD_WIDTH = pkeh_pkg::COORD_WIDTH_DEF)
  (input  logic         clk,
   input  logic         rst,
   input  logic         s_tvalid,
   output logic         s_tready,
   // key_y, key_x, left_id, right_id, param_left, param_right, target_slot
   input  logic [167:0] s_tdata,
   // action
   input  logic [1:0]   s_tuser,
   output logic         m_tvalid,
   input  logic         m_tready,
   // slot, out_key_y, out_key_x, out_left_id, out_right_id, out_param_left,
   // out_param_right, relocated, relocated_from, relocated_to, zero pad
   output logic [191:0] m_tdata,
   // status
   output logic [1:0]   m_tuser,
   input  logic         cfg_valid,
   output logic         cfg_ready,
   input  logic [8:0]   cfg_data);

  import pkeh_pkg::*;

  localparam int AW = $clog2(MAX_EVENTS);
  localparam int CNW = AW + 1;
  localparam int CHW = AW + 2;

  function automatic logic key_less(input logic [63:0] a, input logic [63:0] b);
    logic signed [COORD_WIDTH-1:0] ya, yb, xa, xb;
    ya = a[32 +: COORD_WIDTH];
    yb = b[32 +: COORD_WIDTH];
    xa = a[0 +: COORD_WIDTH];
    xb = b[0 +: COORD_WIDTH];
    return (ya < yb) || ((ya == yb) && (xa < xb));
  endfunction

  // memories
  logic [63:0]   key_mem   [MAX_EVENTS];
  logic [31:0]   link_mem  [MAX_EVENTS];
  logic [63:0]   param_mem [MAX_EVENTS];
  logic [AW-1:0] s2p_mem   [MAX_EVENTS];
  logic [AW-1:0] p2s_mem   [MAX_EVENTS];

  logic          pay_we;
  logic [AW-1:0] pay_waddr;
  logic [63:0]   key_wdata, param_wdata;
  logic [31:0]   link_wdata;
  logic [AW-1:0] key_raddr, pay_raddr;
  logic [63:0]   key_rdata, param_rdata;
  logic [31:0]   link_rdata;

  logic          s2p_we, p2s_we;
  logic [AW-1:0] s2p_waddr, s2p_wdata, p2s_waddr, p2s_wdata;
  logic [AW-1:0] s2p_raddr, p2s_raddr;
  logic [AW-1:0] s2p_rdata, p2s_rdata;

  always_ff @(posedge clk) begin
    if (pay_we) begin
      key_mem[pay_waddr]   <= key_wdata;
      link_mem[pay_waddr]  <= link_wdata;
      param_mem[pay_waddr] <= param_wdata;
    end
    key_rdata   <= key_mem[key_raddr];
    link_rdata  <= link_mem[pay_raddr];
    param_rdata <= param_mem[pay_raddr];
  end

  always_ff @(posedge clk) begin
    if (s2p_we) s2p_mem[s2p_waddr] <= s2p_wdata;
    s2p_rdata <= s2p_mem[s2p_raddr];
  end

  always_ff @(posedge clk) begin
    if (p2s_we) p2s_mem[p2s_waddr] <= p2s_wdata;
    p2s_rdata <= p2s_mem[p2s_raddr];
  end

  // registers
  state_t         state, state_next;
  logic [8:0]     capacity;
  logic [CNW-1:0] cnt;
  logic [1:0]     action;
  logic [63:0]    in_key, in_param;
  logic [31:0]    in_link;
  logic [AW-1:0]  sel, npos, ent, cur, nslot, ssel, csel, s1;
  logic [63:0]    ent_key, k1;
  logic           climbed, dn_last;
  logic [1:0]     r_status;
  logic [7:0]     r_slot, r_from, r_to;
  logic [63:0]    r_key, r_param;
  logic [31:0]    r_link;
  logic           r_rel;

  logic [31:0]    lim32;
  logic           full;
  logic [AW-1:0]  half, last;
  logic [CHW-1:0] c1w, c2w;
  logic           s_acc;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign lim32 = (32'(capacity) < 32'(MAX_EVENTS)) ? 32'(capacity) : 32'(MAX_EVENTS);
  assign full  = 32'(cnt) >= lim32;
  assign half  = (cur - 1'b1) >> 1;
  assign last  = AW'(cnt - 1'b1);
  assign c1w   = CHW'({cur, 1'b1});
  assign c2w   = c1w + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    pay_we      = 1'b0;
    pay_waddr   = sel;
    key_wdata   = in_key;
    link_wdata  = in_link;
    param_wdata = in_param;
    key_raddr   = sel;
    pay_raddr   = sel;
    s2p_we      = 1'b0;
    s2p_waddr   = ent;
    s2p_wdata   = cur;
    s2p_raddr   = sel;
    p2s_we      = 1'b0;
    p2s_waddr   = cur;
    p2s_wdata   = ent;
    p2s_raddr   = '0;
    case (state)
      S_IDLE: begin
        if (s_acc) begin
          case (s_tuser)
            ACT_INSERT: begin
              if (full) state_next = S_DONE;
              else begin
                pay_we      = 1'b1;
                pay_waddr   = AW'(cnt);
                key_wdata   = {s_tdata[31:0], s_tdata[63:32]};
                link_wdata  = {s_tdata[79:64], s_tdata[95:80]};
                param_wdata = {s_tdata[127:96], s_tdata[159:128]};
                s2p_we      = 1'b1;
                s2p_waddr   = AW'(cnt);
                s2p_wdata   = AW'(cnt);
                p2s_we      = 1'b1;
                p2s_waddr   = AW'(cnt);
                p2s_wdata   = AW'(cnt);
                state_next  = (cnt == '0) ? S_DONE : S_UP_RD;
              end
            end
            ACT_REMOVE: begin
              if (32'(s_tdata[167:160]) >= 32'(cnt)) state_next = S_DONE;
              else state_next = S_REP_RD;
            end
            default: begin
              p2s_raddr  = '0;
              state_next = (cnt == '0) ? S_DONE : S_TOP_WAIT;
            end
          endcase
        end
      end
      S_TOP_WAIT: state_next = S_REP_RD;
      S_REP_RD: begin
        key_raddr  = sel;
        pay_raddr  = sel;
        s2p_raddr  = sel;
        state_next = S_REP;
      end
      S_REP: begin
        if (action == ACT_PEEK || cnt <= CNW'(1)) state_next = S_DONE;
        else if (last != sel) state_next = S_MOVE_RD;
        else if (s2p_rdata == last) state_next = S_DONE;
        else state_next = S_ENT_RD;
      end
      S_MOVE_RD: begin
        key_raddr  = AW'(cnt);
        pay_raddr  = AW'(cnt);
        s2p_raddr  = AW'(cnt);
        state_next = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        pay_we      = 1'b1;
        pay_waddr   = sel;
        key_wdata   = key_rdata;
        link_wdata  = link_rdata;
        param_wdata = param_rdata;
        p2s_we      = 1'b1;
        p2s_waddr   = s2p_rdata;
        p2s_wdata   = sel;
        s2p_we      = 1'b1;
        s2p_waddr   = sel;
        s2p_wdata   = s2p_rdata;
        state_next  = (npos == AW'(cnt)) ? S_DONE : S_ENT_RD;
      end
      S_ENT_RD: begin
        p2s_raddr  = AW'(cnt);
        state_next = S_ENT_WAIT;
      end
      S_ENT_WAIT: begin
        key_raddr  = p2s_rdata;
        p2s_we     = 1'b1;
        p2s_waddr  = npos;
        p2s_wdata  = p2s_rdata;
        s2p_we     = 1'b1;
        s2p_waddr  = p2s_rdata;
        s2p_wdata  = npos;
        state_next = S_ENT_KEY;
      end
      S_ENT_KEY: state_next = (cur == '0) ? S_DN_RD : S_UP_RD;
      S_UP_RD: begin
        p2s_raddr  = half;
        state_next = S_UP_WAIT;
      end
      S_UP_WAIT: begin
        key_raddr  = p2s_rdata;
        state_next = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (key_less(ent_key, key_rdata)) begin
          p2s_we     = 1'b1;
          p2s_waddr  = half;
          p2s_wdata  = ent;
          s2p_we     = 1'b1;
          s2p_waddr  = ent;
          s2p_wdata  = half;
          state_next = S_UP_WR2;
        end else if (action == ACT_INSERT || climbed) state_next = S_DONE;
        else state_next = S_DN_RD;
      end
      S_UP_WR2: begin
        p2s_we     = 1'b1;
        p2s_waddr  = cur;
        p2s_wdata  = nslot;
        s2p_we     = 1'b1;
        s2p_waddr  = nslot;
        s2p_wdata  = cur;
        state_next = (half == '0) ? S_DONE : S_UP_RD;
      end
      S_DN_RD: begin
        p2s_raddr  = AW'(c1w);
        state_next = (c1w >= CHW'(cnt)) ? S_DONE : S_DN_W1;
      end
      S_DN_W1: begin
        key_raddr  = p2s_rdata;
        state_next = S_DN_K1;
      end
      S_DN_K1: begin
        p2s_raddr = AW'(c2w);
        if (c2w < CHW'(cnt)) state_next = S_DN_W2;
        else if (key_less(key_rdata, ent_key)) state_next = S_DN_SW1;
        else state_next = S_DONE;
      end
      S_DN_W2: begin
        key_raddr  = p2s_rdata;
        state_next = S_DN_K2;
      end
      S_DN_K2: begin
        if (key_less(k1, ent_key) || key_less(key_rdata, ent_key)) state_next = S_DN_SW1;
        else state_next = S_DONE;
      end
      S_DN_SW1: begin
        p2s_we     = 1'b1;
        p2s_waddr  = csel;
        p2s_wdata  = ent;
        s2p_we     = 1'b1;
        s2p_waddr  = ent;
        s2p_wdata  = csel;
        state_next = S_DN_SW2;
      end
      S_DN_SW2: begin
        p2s_we     = 1'b1;
        p2s_waddr  = cur;
        p2s_wdata  = ssel;
        s2p_we     = 1'b1;
        s2p_waddr  = ssel;
        s2p_wdata  = cur;
        state_next = dn_last ? S_DONE : S_DN_RD;
      end
      S_DONE: if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RST;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) capacity <= cfg_data;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == S_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      if (state == S_IDLE && s_acc && s_tuser == ACT_INSERT && !full) cnt <= cnt + 1'b1;
      if (state == S_REP && action != ACT_PEEK) begin
        if (cnt <= CNW'(1)) cnt <= '0;
        else cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        action   <= s_tuser;
        in_key   <= {s_tdata[31:0], s_tdata[63:32]};
        in_link  <= {s_tdata[79:64], s_tdata[95:80]};
        in_param <= {s_tdata[127:96], s_tdata[159:128]};
        r_status <= ST_OK;
        r_slot   <= '0;
        r_key    <= '0;
        r_link   <= '0;
        r_param  <= '0;
        r_rel    <= 1'b0;
        r_from   <= '0;
        r_to     <= '0;
        climbed  <= 1'b0;
        dn_last  <= 1'b0;
        sel      <= AW'(s_tdata[167:160]);
        ent      <= AW'(cnt);
        cur      <= AW'(cnt);
        ent_key  <= {s_tdata[31:0], s_tdata[63:32]};
        case (s_tuser)
          ACT_INSERT: begin
            if (full) r_status <= ST_FULL;
            else r_slot <= 8'(cnt);
          end
          ACT_REMOVE: begin
            if (32'(s_tdata[167:160]) >= 32'(cnt)) r_status <= ST_EMPTY;
          end
          default: if (cnt == '0) r_status <= ST_EMPTY;
        endcase
      end
      S_TOP_WAIT: sel <= p2s_rdata;
      S_REP: begin
        r_slot  <= 8'(sel);
        r_key   <= key_rdata;
        r_link  <= link_rdata;
        r_param <= param_rdata;
        npos    <= s2p_rdata;
        cur     <= s2p_rdata;
      end
      S_MOVE_WR: begin
        r_rel  <= 1'b1;
        r_from <= 8'(cnt);
        r_to   <= 8'(sel);
      end
      S_ENT_WAIT: ent <= p2s_rdata;
      S_ENT_KEY: ent_key <= key_rdata;
      S_UP_WAIT: nslot <= p2s_rdata;
      S_UP_WR2: begin
        cur     <= half;
        climbed <= 1'b1;
      end
      S_DN_W1: s1 <= p2s_rdata;
      S_DN_K1: begin
        k1      <= key_rdata;
        csel    <= AW'(c1w);
        ssel    <= s1;
        dn_last <= 1'b1;
      end
      S_DN_W2: begin
        nslot   <= p2s_rdata;
        dn_last <= 1'b0;
      end
      S_DN_K2: begin
        if (!(key_less(k1, ent_key) && key_less(k1, key_rdata))) begin
          csel <= AW'(c2w);
          ssel <= nslot;
        end
      end
      S_DN_SW2: cur <= csel;
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tuser <= r_status;
          m_tdata <= {7'd0, r_to, r_from, r_rel, r_param[31:0], r_param[63:32],
                      r_link[15:0], r_link[31:16], r_key[31:0], r_key[63:32], r_slot};
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/pkeh_checker.sv]
module pkeh_assert_checker
  (input logic         clk,
   input logic         rst,
   input logic         m_tvalid,
   input logic         m_tready,
   input logic [191:0] m_tdata,
   input logic [1:0]   m_tuser);

  import pkeh_pkg::*;

`include "point_keyed_event_heap_unit_assert.svh"

  `PKEH_CHECK(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped")
  `PKEH_CHECK(a_code, m_tvalid |-> m_tuser <= ST_EMPTY, "bad status code")
  `PKEH_CHECK(a_full, m_tvalid && m_tuser == ST_FULL |-> m_tdata == '0, "full result not zero")
  `PKEH_CHECK(a_move, m_tvalid && !m_tdata[168] |-> m_tdata[184:169] == '0, "move fields set")

endmodule

bind point_keyed_event_heap_unit pkeh_assert_checker u_pkeh_assert_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser));

[dv/pkeh_checker.sv]
module pkeh_checker
  (input  logic         clk,
   input  logic         rst,
   input  logic         s_tvalid,
   input  logic         s_tready,
   input  logic [167:0] s_tdata,
   input  logic [1:0]   s_tuser,
   input  logic         m_tvalid,
   input  logic         m_tready,
   input  logic [191:0] m_tdata,
   input  logic [1:0]   m_tuser,
   input  logic         cfg_valid,
   input  logic         cfg_ready,
   input  logic [8:0]   cfg_data,
   output int           fail_count,
   output int           pending);

  timeunit 1ns;
  timeprecision 1ps;

  import pkeh_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [31:0] ky;
    logic [31:0] kx;
    logic [15:0] lid;
    logic [15:0] rid;
    logic [31:0] pl;
    logic [31:0] pr;
    logic        moved;
    logic [7:0]  mfrom;
    logic [7:0]  mto;
  } heap_result_t;

  logic [8:0]  cap_reg;
  int          count;
  logic [63:0] keys   [256];
  logic [31:0] links  [256];
  logic [63:0] params [256];
  int          slot_pos [256];
  int          pos_slot [256];
  heap_result_t result_q[$];

  assign pending = result_q.size();

  function automatic bit orders_before(int a, int b);
    logic signed [31:0] ya, yb, xa, xb;
    ya = keys[a][63:32]; yb = keys[b][63:32];
    xa = keys[a][31:0];  xb = keys[b][31:0];
    return ya < yb || (ya == yb && xa < xb);
  endfunction

  function automatic void set_pos(int p, int s);
    pos_slot[p] = s;
    slot_pos[s] = p;
  endfunction

  function automatic void delete_slot(int s, ref heap_result_t r);
    int n, last, ent, cur, half, par, c1, c2, s1, s2;
    bit climbed;
    climbed = 0;
    if (count <= 1) begin
      count = 0;
      return;
    end
    n = slot_pos[s];
    last = count - 1;
    if (last != s) begin
      keys[s] = keys[last];
      links[s] = links[last];
      params[s] = params[last];
      set_pos(slot_pos[last], s);
      r.moved = 1; r.mfrom = 8'(last); r.mto = 8'(s);
    end
    count = last;
    if (n == count) return;
    ent = pos_slot[count];
    set_pos(n, ent);
    cur = n;
    while (cur > 0) begin
      half = (cur - 1) / 2;
      par = pos_slot[half];
      if (!orders_before(ent, par)) break;
      set_pos(half, ent); set_pos(cur, par);
      climbed = 1;
      cur = half;
    end
    if (climbed) return;
    while (2 * cur + 1 < count) begin
      c1 = 2 * cur + 1; c2 = c1 + 1;
      s1 = pos_slot[c1];
      if (c2 < count) begin
        s2 = pos_slot[c2];
        if (orders_before(s1, ent)) begin
          if (orders_before(s1, s2)) begin
            set_pos(c1, ent); set_pos(cur, s1); cur = c1;
          end else begin
            set_pos(c2, ent); set_pos(cur, s2); cur = c2;
          end
        end else if (orders_before(s2, ent)) begin
          set_pos(c2, ent); set_pos(cur, s2); cur = c2;
        end else begin
          break;
        end
      end else begin
        if (orders_before(s1, ent)) begin
          set_pos(c1, ent); set_pos(cur, s1);
        end
        break;
      end
    end
  endfunction

  function automatic heap_result_t apply_word(logic [1:0] act, logic [167:0] d);
    heap_result_t r;
    int lim, s, cur, half, par;
    r = '0;
    lim = (cap_reg > 256) ? 256 : cap_reg;
    if (act == ACT_INSERT) begin
      if (count >= lim) begin
        r.status = ST_FULL;
        return r;
      end
      s = count++;
      keys[s] = {d[31:0], d[63:32]};
      links[s] = {d[79:64], d[95:80]};
      params[s] = {d[127:96], d[159:128]};
      set_pos(s, s);
      cur = s;
      while (cur > 0) begin
        half = (cur - 1) / 2;
        par = pos_slot[half];
        if (!orders_before(s, par)) break;
        set_pos(half, s); set_pos(cur, par);
        cur = half;
      end
      r.slot = 8'(s);
      return r;
    end
    if (act == ACT_REMOVE) begin
      s = d[167:160];
      if (s >= count) begin
        r.status = ST_EMPTY;
        return r;
      end
    end else begin
      if (count == 0) begin
        r.status = ST_EMPTY;
        return r;
      end
      s = pos_slot[0];
    end
    r.slot = 8'(s);
    {r.ky, r.kx} = keys[s];
    {r.lid, r.rid} = links[s];
    {r.pl, r.pr} = params[s];
    if (act != ACT_PEEK) delete_slot(s, r);
    return r;
  endfunction

  always @(posedge clk) begin
    heap_result_t e, a;
    if (rst) begin
      cap_reg <= CAPACITY_RST;
      count = 0;
      result_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) cap_reg <= cfg_data;
      if (s_tvalid && s_tready) result_q.push_back(apply_word(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        a.status = m_tuser;
        {a.mto, a.mfrom, a.moved, a.pr, a.pl, a.rid, a.lid, a.kx, a.ky, a.slot} =
          m_tdata[184:0];
        if (result_q.size() == 0) begin
          $error("result word with none expected");
          fail_count <= fail_count + 1;
        end else begin
          e = result_q.pop_front();
          if (e != a) begin
            if (e.status != a.status) $error("status exp %0d got %0d", e.status, a.status);
            if (e.slot != a.slot) $error("slot exp %0d got %0d", e.slot, a.slot);
            if (e.ky != a.ky) $error("out_key_y exp %h got %h", e.ky, a.ky);
            if (e.kx != a.kx) $error("out_key_x exp %h got %h", e.kx, a.kx);
            if (e.lid != a.lid) $error("out_left_id exp %h got %h", e.lid, a.lid);
            if (e.rid != a.rid) $error("out_right_id exp %h got %h", e.rid, a.rid);
            if (e.pl != a.pl) $error("out_param_left exp %h got %h", e.pl, a.pl);
            if (e.pr != a.pr) $error("out_param_right exp %h got %h", e.pr, a.pr);
            if (e.moved != a.moved) $error("relocated exp %0d got %0d", e.moved, a.moved);
            if (e.mfrom != a.mfrom)
              $error("relocated_from exp %0d got %0d", e.mfrom, a.mfrom);
            if (e.mto != a.mto) $error("relocated_to exp %0d got %0d", e.mto, a.mto);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[dv/tb_point_keyed_event_heap_unit.sv]
module tb_point_keyed_event_heap_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pkeh_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [167:0] s_tdata = '0;
  logic [1:0]   s_tuser = ACT_PEEK;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [191:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [8:0]   cfg_data = '0;
  int           fail_count;
  int           pending;
  int           cycles = 0;
  int           model_count = 0;
  bit           calm = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  point_keyed_event_heap_unit u_top (.*);

  pkeh_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side stalls
  always @(posedge clk) begin
    if (rst || calm) m_tready <= !rst;
    else if (!m_tready) m_tready <= 1;
    else if ($urandom_range(0, 5) == 0) m_tready <= 0;
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 7);
      3: return $urandom_range(0, 7) << 16;
      default: return $urandom;
    endcase
  endfunction

  // s_tvalid stays high after a word until a gap or a drain drops it
  task automatic send_word(logic [1:0] act, logic [7:0] tslot, bit rnd_fields);
    logic [167:0] d;
    int gap;
    d = {tslot, 32'h0, 32'h0, 16'h0, 16'h0, pick_coord(), pick_coord()};
    if (rnd_fields) d[159:64] = {$urandom, $urandom, $urandom};
    else if ($urandom_range(0, 1)) d[159:64] = '1;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= act;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // track occupancy loosely to steer the mix
    if (act == ACT_INSERT) model_count++;
    else if (act != ACT_PEEK && model_count > 0) model_count--;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cap(logic [8:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_phase(int n, int fill_bias);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < fill_bias) send_word(ACT_INSERT, 8'($urandom), 1);
      else if (r < fill_bias + 10) send_word(ACT_PEEK, 8'($urandom), 1);
      else if (r < fill_bias + 30 || model_count == 0)
        send_word(ACT_EXTRACT, 8'($urandom), 1);
      else send_word(ACT_REMOVE, 8'($urandom_range(0, model_count)), 1);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: empty cases, extremes, ties
    send_word(ACT_PEEK, 0, 0);
    send_word(ACT_EXTRACT, 0, 0);
    send_word(ACT_REMOVE, 0, 0);
    send_word(ACT_INSERT, 8'hff, 0);
    send_word(ACT_REMOVE, 8'hff, 0);
    repeat (8) send_word(ACT_INSERT, 0, 0);
    send_word(ACT_PEEK, 0, 0);
    send_word(ACT_REMOVE, 7, 0);
    send_word(ACT_REMOVE, 0, 0);
    repeat (6) send_word(ACT_EXTRACT, 0, 0);
    drain();
    write_cap(0);
    send_word(ACT_INSERT, 0, 0);
    drain();
    write_cap(3);
    random_phase(60, 55);
    drain();
    write_cap(1);
    random_phase(30, 60);
    drain();
    write_cap(511);
    random_phase(300, 70);
    drain();
    write_cap(256);
    random_phase(150, 45);
    drain();
    write_cap(9'($urandom_range(2, 40)));
    random_phase(80, 55);
    calm = 1;
    random_phase(80, 45);
    drain();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
